// File: design/asam_pkg.sv
package asam_pkg;

  localparam int DEPTH       = 64;
  localparam int MAX_RESULTS = 64;
  localparam int WORD_W      = 32;
  localparam int MATCH_W     = 6;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = CNT_W + 1;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LINEAR = 2'd2,
    CMD_BINARY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCMP,
    ST_BCHK,
    ST_BCMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [MATCH_W-1:0] idx;
    logic               found;
    logic               last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

// File: design/asam_mem.sv
module asam_mem (
  input  logic                          clk,
  input  asam_pkg::mem_req_t            req,
  output logic [asam_pkg::WORD_W-1:0]   rd_data
);
  import asam_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

// File: design/asam_seq.sv
module asam_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [1:0]                   in_command,
  input  logic [asam_pkg::WORD_W-1:0]  in_word_value,
  output logic                         in_stall,
  input  logic                         out_free,
  output asam_pkg::res_t               res,
  output asam_pkg::mem_req_t           mem_req,
  input  logic [asam_pkg::WORD_W-1:0]  rd_data
);
  import asam_pkg::*;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [WORD_W-1:0]        key_r, key_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [N_W-1:0]           n_r, n_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic signed [POS_W-1:0]  left_r, left_nxt;
  logic signed [POS_W-1:0]  right_r, right_nxt;
  logic                     prev_valid_r, prev_valid_nxt;
  logic [IDX_W-1:0]         prev_r, prev_nxt;

  logic                     accept;
  logic                     eq, lt;
  logic                     bin_new_hit;
  logic                     push_req, blocked;
  logic                     lin_end;
  logic                     bin_go;
  logic [POS_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic signed [POS_W-1:0]  idx_pos;

  assign in_stall    = (state_r != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign eq          = ($signed(rd_data) == $signed(key_r));
  assign lt          = ($signed(rd_data) < $signed(key_r));
  assign bin_new_hit = eq && !(prev_valid_r && (prev_r == idx_r));
  assign idx_pos     = $signed({{(POS_W - IDX_W){1'b0}}, idx_r});
  assign mid_sum     = {left_r[POS_W-1], left_r} + {right_r[POS_W-1], right_r};
  assign mid         = mid_sum[IDX_W:1];
  assign bin_go      = (left_r <= right_r) && (n_r < N_W'(MAX_RESULTS));
  assign lin_end     = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r)
                       || (eq && ((n_r + N_W'(1)) == N_W'(MAX_RESULTS)));

  always_comb begin
    push_req = 1'b0;
    res      = '0;
    unique case (state_r)
      ST_LCMP: begin
        push_req = eq && pend_valid_r;
      end
      ST_BCMP: begin
        push_req = bin_new_hit && pend_valid_r;
      end
      ST_FIN: begin
        push_req = 1'b1;
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
    blocked   = push_req && !out_free;
    res.valid = push_req && out_free;
    res.idx   = pend_valid_r ? MATCH_W'(pend_idx_r) : '0;
    res.found = pend_valid_r;
    res.last  = (state_r == ST_FIN);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LINEAR) begin
            state_nxt = (count_r == '0) ? ST_FIN : ST_LCMP;
          end else if (in_command == CMD_BINARY) begin
            state_nxt = ST_BCHK;
          end
        end
      end
      ST_LCMP: begin
        if (!blocked && lin_end) begin
          state_nxt = ST_FIN;
        end
      end
      ST_BCHK: begin
        state_nxt = bin_go ? ST_BCMP : ST_FIN;
      end
      ST_BCMP: begin
        if (!blocked) begin
          state_nxt = ST_BCHK;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    prev_valid_nxt = prev_valid_r;
    prev_nxt       = prev_r;
    mem_req.we     = 1'b0;
    mem_req.waddr  = count_r[IDX_W-1:0];
    mem_req.wdata  = in_word_value;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt        = in_word_value;
          idx_nxt        = '0;
          n_nxt          = '0;
          pend_valid_nxt = 1'b0;
          left_nxt       = '0;
          right_nxt      = $signed({1'b0, count_r}) - POS_W'(1);
          prev_valid_nxt = 1'b0;
          if (in_command == CMD_CLEAR) begin
            count_nxt = '0;
          end else if (in_command == CMD_APPEND) begin
            if (count_r < CNT_W'(DEPTH)) begin
              mem_req.we = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
            end
          end
        end
      end
      ST_LCMP: begin
        if (!blocked) begin
          if (eq) begin
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = idx_r;
            n_nxt          = n_r + N_W'(1);
          end
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_BCHK: begin
        idx_nxt = mid;
      end
      ST_BCMP: begin
        if (!blocked) begin
          if (lt) begin
            left_nxt = idx_pos + POS_W'(1);
          end else if (!eq) begin
            right_nxt = idx_pos - POS_W'(1);
          end else begin
            if (bin_new_hit) begin
              pend_valid_nxt = 1'b1;
              pend_idx_nxt   = idx_r;
              n_nxt          = n_r + N_W'(1);
            end
            left_nxt       = left_r + POS_W'(1);
            prev_valid_nxt = 1'b1;
            prev_nxt       = idx_r;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
    mem_req.raddr = idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      prev_valid_r <= 1'b0;
      n_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      prev_valid_r <= prev_valid_nxt;
      n_r          <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    prev_r     <= prev_nxt;
  end

endmodule

// File: design/array_search_all_matches.sv
// Channel  Ports                                              Direction
// input    in_valid, in_stall, in_command, in_word_value      request in
// result   out_valid, out_stall, out_match_index, out_found,  request out
//          out_last_result
//
// Clear and append leave the sequencer idle, so they never raise in_stall.
// A linear search steps through the stored words, paced by the single memory read
// port and the compare unit, which check one word per cycle while out_free holds.
// Each binary search loop step computes the address, then compares the word.
// Reset empties the array and the result register; stored words stay undefined.
// A stalled result register holds the search at its next hit or its final result.
module array_search_all_matches (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic signed [asam_pkg::WORD_W-1:0]  in_word_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [asam_pkg::MATCH_W-1:0]        out_match_index,
  output logic                                out_found,
  output logic                                out_last_result
);
  import asam_pkg::*;

  res_t               res;
  mem_req_t           mem_req;
  logic [WORD_W-1:0]  rd_data;
  logic               out_free;
  logic               out_valid_r;
  logic [MATCH_W-1:0] out_idx_r;
  logic               out_found_r;
  logic               out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  asam_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_command    (in_command),
    .in_word_value (in_word_value),
    .in_stall      (in_stall),
    .out_free      (out_free),
    .res           (res),
    .mem_req       (mem_req),
    .rd_data       (rd_data)
  );

  asam_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_idx_r   <= res.idx;
      out_found_r <= res.found;
      out_last_r  <= res.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_idx_r;
  assign out_found       = out_found_r;
  assign out_last_result = out_last_r;

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last_result && (out_match_index == '0))
    else $error("not-found result must be last with index zero");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command[1] |=> in_stall)
    else $error("search request must hold the input");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result pushed into an occupied output register");

endmodule

// File: verif/testbench.sv
module testbench;
  import asam_pkg::*;

  localparam int RANDOM_REQUESTS = 240;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = DEPTH + 8;
  localparam int DIRECTED_ROWS   = 22;

  typedef struct packed {
    logic [MATCH_W-1:0] idx;
    logic               found;
    logic               last;
  } hit_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [WORD_W-1:0]  word;
    logic               typed;
    logic [MATCH_W-1:0] idx;
    logic               found;
  } directed_row_t;

  // typed rows carry their single expected result; the rest go through the predictor
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_LINEAR, 32'h0000_0000, 1'b1, 6'd0, 1'b0},
    '{CMD_BINARY, 32'hFFFF_FFFF, 1'b1, 6'd0, 1'b0},
    '{CMD_APPEND, 32'h8000_0000, 1'b0, 6'd0, 1'b0},
    '{CMD_APPEND, 32'hFFFF_FFFF, 1'b0, 6'd0, 1'b0},
    '{CMD_APPEND, 32'h0000_0000, 1'b0, 6'd0, 1'b0},
    '{CMD_APPEND, 32'h0000_0000, 1'b0, 6'd0, 1'b0},
    '{CMD_APPEND, 32'h7FFF_FFFF, 1'b0, 6'd0, 1'b0},
    '{CMD_LINEAR, 32'h8000_0000, 1'b1, 6'd0, 1'b1},
    '{CMD_LINEAR, 32'h7FFF_FFFF, 1'b1, 6'd4, 1'b1},
    '{CMD_LINEAR, 32'h0000_0000, 1'b0, 6'd0, 1'b0},
    '{CMD_BINARY, 32'h0000_0000, 1'b0, 6'd0, 1'b0},
    '{CMD_BINARY, 32'h7FFF_FFFF, 1'b0, 6'd0, 1'b0},
    '{CMD_LINEAR, 32'h0000_0005, 1'b1, 6'd0, 1'b0},
    '{CMD_BINARY, 32'h0000_0005, 1'b1, 6'd0, 1'b0},
    '{CMD_CLEAR,  32'hFFFF_FFFF, 1'b0, 6'd0, 1'b0},
    '{CMD_LINEAR, 32'h0000_0000, 1'b1, 6'd0, 1'b0},
    '{CMD_APPEND, 32'h0000_0003, 1'b0, 6'd0, 1'b0},
    '{CMD_APPEND, 32'h0000_0001, 1'b0, 6'd0, 1'b0},
    '{CMD_APPEND, 32'h0000_0002, 1'b0, 6'd0, 1'b0},
    '{CMD_BINARY, 32'h0000_0001, 1'b0, 6'd0, 1'b0},
    '{CMD_BINARY, 32'h0000_0003, 1'b0, 6'd0, 1'b0},
    '{CMD_LINEAR, 32'h0000_0002, 1'b0, 6'd0, 1'b0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_command = CMD_CLEAR;
  logic signed [WORD_W-1:0]  in_word_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [MATCH_W-1:0]        out_match_index;
  logic                      out_found;
  logic                      out_last_result;

  logic signed [WORD_W-1:0]  shadow_words [DEPTH];
  int                        shadow_count = 0;
  hit_t                      hits_due [$];

  int requests_sent   = 0;
  int linear_runs     = 0;
  int binary_runs     = 0;
  int appends_dropped = 0;
  int results_checked = 0;
  int misses_seen     = 0;
  int longest_run     = 0;
  int failures        = 0;
  int burst_left      = 0;
  int cycle_count     = 0;
  int stall_mode      = 0;
  int mode_left       = 0;

  array_search_all_matches uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_word_value   (in_word_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_index (out_match_index),
    .out_found       (out_found),
    .out_last_result (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_search_hits(input cmd_t cmd,
                                              input logic signed [WORD_W-1:0] word);
    int hit_list [$];
    int lo;
    int hi;
    int mid;
    int prev;
    int i;
    hit_list.delete();
    case (cmd)
      CMD_CLEAR: shadow_count = 0;
      CMD_APPEND: begin
        if (shadow_count < DEPTH) begin
          shadow_words[shadow_count] = word;
          shadow_count++;
        end else begin
          appends_dropped++;
        end
      end
      CMD_LINEAR: begin
        for (i = 0; i < shadow_count && hit_list.size() < MAX_RESULTS; i++)
          if (shadow_words[i] == word) hit_list.push_back(i);
      end
      default: begin
        lo = 0;
        hi = shadow_count - 1;
        prev = -1;
        while (lo <= hi && hit_list.size() < MAX_RESULTS) begin
          mid = (lo + hi) / 2;
          if (shadow_words[mid] < word) begin
            lo = mid + 1;
          end else if (shadow_words[mid] > word) begin
            hi = mid - 1;
          end else begin
            if (mid != prev) hit_list.push_back(mid);
            lo++;
            prev = mid;
          end
        end
      end
    endcase
    if (cmd == CMD_LINEAR || cmd == CMD_BINARY) begin
      if (hit_list.size() == 0) begin
        hits_due.push_back('{idx: '0, found: 1'b0, last: 1'b1});
      end else begin
        for (i = 0; i < hit_list.size(); i++)
          hits_due.push_back('{idx: MATCH_W'(hit_list[i]), found: 1'b1,
                               last: (i == hit_list.size() - 1)});
      end
      if (hit_list.size() > longest_run) longest_run = hit_list.size();
    end
  endfunction

  task automatic send_request(input cmd_t cmd, input logic signed [WORD_W-1:0] word,
                              input logic typed = 1'b0,
                              input logic [MATCH_W-1:0] t_idx = '0,
                              input logic t_found = 1'b0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_word_value <= word;
    do @(posedge clk); while (in_stall);
    burst_left--;
    requests_sent++;
    if (cmd == CMD_LINEAR) linear_runs++;
    if (cmd == CMD_BINARY) binary_runs++;
    if (typed) hits_due.push_back('{idx: t_idx, found: t_found, last: 1'b1});
    else predict_search_hits(cmd, word);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    logic signed [WORD_W-1:0] batch [$];
    logic signed [WORD_W-1:0] base;
    logic signed [WORD_W-1:0] key;
    int n_words;
    int pool;
    int r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (r = 0; r < DIRECTED_ROWS; r++)
      send_request(DIRECTED[r].cmd, DIRECTED[r].word, DIRECTED[r].typed,
                   DIRECTED[r].idx, DIRECTED[r].found);
    drain_results();

    // overfill with one value: appends past capacity drop, search hits the result limit
    base = $urandom;
    send_request(CMD_CLEAR, $urandom);
    repeat (DEPTH + 2) send_request(CMD_APPEND, base);
    send_request(CMD_LINEAR, base);
    send_request(CMD_BINARY, base);
    send_request(CMD_LINEAR, ~base);

    while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS) begin
      if ($urandom_range(0, 99) < 15) begin
        send_request(cmd_t'($urandom_range(0, 3)), $urandom);
      end else begin
        if ($urandom_range(0, 4) != 0) send_request(CMD_CLEAR, $urandom);
        n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
        pool = $urandom_range(0, 2);
        base = $urandom;
        batch.delete();
        repeat (n_words) begin
          case (pool)
            0: batch.push_back(base + $urandom_range(0, 3));
            1: batch.push_back($urandom);
            default: begin
              case ($urandom_range(0, 4))
                0: batch.push_back(32'sh8000_0000);
                1: batch.push_back(32'sh7FFF_FFFF);
                2: batch.push_back(-32'sd1);
                3: batch.push_back(32'sd0);
                default: batch.push_back(32'sd1);
              endcase
            end
          endcase
        end
        if ($urandom_range(0, 4) != 0) batch.sort();
        foreach (batch[i]) send_request(CMD_APPEND, batch[i]);
        repeat ($urandom_range(1, 4)) begin
          key = $urandom;
          if (batch.size() > 0) begin
            case ($urandom_range(0, 4))
              0, 1, 2: key = batch[$urandom_range(0, batch.size() - 1)];
              3: key = batch[$urandom_range(0, batch.size() - 1)] + 1;
              default: key = batch[$urandom_range(0, batch.size() - 1)] - 1;
            endcase
          end
          send_request($urandom_range(0, 1) ? CMD_LINEAR : CMD_BINARY, key);
        end
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end

    drain_results();
    $display("Sent %0d requests: %0d linear and %0d binary searches, %0d appends dropped.",
             requests_sent, linear_runs, binary_runs, appends_dropped);
    $display("Checked %0d results, %0d not-found; longest search returned %0d hits.",
             results_checked, misses_seen, longest_run);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    hit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_due.size() == 0) begin
        $error("unexpected result: match_index %0d found %0b last_result %0b",
               out_match_index, out_found, out_last_result);
        failures++;
      end else begin
        want = hits_due.pop_front();
        results_checked++;
        if (!want.found) misses_seen++;
        if (out_match_index !== want.idx) begin
          $error("match_index: expected %0d, got %0d", want.idx, out_match_index);
          failures++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_found);
          failures++;
        end
        if (out_last_result !== want.last) begin
          $error("last_result: expected %0b, got %0b", want.last, out_last_result);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycle_count % 16) < 5);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
